[hw/rtl/hsvrt_pkg.sv]
package hsvrt_pkg;

    // Pixel and result widths
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 9;

    // Divider shape: numerator is {remainder part, quotient part}
    localparam int DIV_DEN_W     = CHAN_W;
    localparam int DIV_QUO_W     = CHAN_W;
    localparam int DIV_NUM_W     = DIV_DEN_W + DIV_QUO_W;
    localparam int DIV_STEP_BITS = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = HUE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_LOW    = 3'd0,
        REG_HUE_HIGH   = 3'd1,
        REG_SAT_LOW    = 3'd2,
        REG_SAT_HIGH   = 3'd3,
        REG_VALUE_LOW  = 3'd4,
        REG_VALUE_HIGH = 3'd5
    } cfg_index_t;

    // Reset values of the bounds
    localparam logic [HUE_W-1:0]  HUE_LOW_RST    = 9'd0;
    localparam logic [HUE_W-1:0]  HUE_HIGH_RST   = 9'd359;
    localparam logic [CHAN_W-1:0] SAT_LOW_RST    = 8'd0;
    localparam logic [CHAN_W-1:0] SAT_HIGH_RST   = 8'd255;
    localparam logic [CHAN_W-1:0] VALUE_LOW_RST  = 8'd0;
    localparam logic [CHAN_W-1:0] VALUE_HIGH_RST = 8'd255;

    // Hue arithmetic, signed 10 bits covers -61..360
    localparam int HUE_S_W = HUE_W + 1;
    localparam logic signed [HUE_S_W-1:0] HUE_BASE_RED   = 10'sd0;
    localparam logic signed [HUE_S_W-1:0] HUE_BASE_GREEN = 10'sd120;
    localparam logic signed [HUE_S_W-1:0] HUE_BASE_BLUE  = 10'sd240;
    localparam logic signed [HUE_S_W-1:0] HUE_FULL_TURN  = 10'sd360;
    localparam logic [HUE_W-1:0]          HUE_MAX        = 9'd359;
    localparam logic [DIV_QUO_W-1:0]      HUE_QUO_MAX    = 8'd60;

    // Which channel holds the maximum (first of red, green, blue)
    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } hue_sector_t;

    // Per-item data travelling alongside the dividers
    typedef struct packed {
        logic [CHAN_W-1:0] value;
        logic [CHAN_W-1:0] delta;
        logic [CHAN_W-1:0] abs_diff;
        logic              diff_neg;
        hue_sector_t       sector;
        logic              last;
    } side_t;

endpackage

[hw/rtl/hsvrt_if.sv]
interface hsvrt_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [hsvrt_pkg::CHAN_W-1:0]   red;
    logic [hsvrt_pkg::CHAN_W-1:0]   green;
    logic [hsvrt_pkg::CHAN_W-1:0]   blue;
    logic                           last_pixel;

    modport source (output valid, red, green, blue, last_pixel, input ready);
    modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface hsvrt_mask_if;
    logic valid;
    logic ready;
    logic in_range;
    logic last_out;

    modport source (output valid, in_range, last_out, input ready);
    modport sink   (input valid, in_range, last_out, output ready);
endinterface

interface hsvrt_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [hsvrt_pkg::CFG_IDX_W-1:0]    index;
    logic [hsvrt_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/hsvrt_div_pipe.sv]
// Pipelined restoring divider, STEP_BITS quotient bits per stage.
// Numerator's upper DEN_W bits must be below den for a valid quotient.
module hsvrt_div_pipe #(
    parameter int DEN_W     = hsvrt_pkg::DIV_DEN_W,
    parameter int QUO_W     = hsvrt_pkg::DIV_QUO_W,
    parameter int STEP_BITS = hsvrt_pkg::DIV_STEP_BITS,
    localparam int STAGES   = QUO_W / STEP_BITS
) (
    input  logic                     clk,
    input  logic [STAGES-1:0]        load,
    input  logic [DEN_W+QUO_W-1:0]   num,
    input  logic [DEN_W-1:0]         den,
    output logic [QUO_W-1:0]         quo,
    output logic [DEN_W-1:0]         rem
);

    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [QUO_W-1:0] low_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];
    logic [DEN_W-1:0] rem_next [STAGES];
    logic [QUO_W-1:0] low_next [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++) begin : g_stage
            logic [DEN_W-1:0] rem_in;
            logic [QUO_W-1:0] low_in;
            logic [DEN_W-1:0] den_in;

            // stage input: fresh operands or previous stage
            if (s == 0) begin : g_first
                assign rem_in = num[DEN_W+QUO_W-1:QUO_W];
                assign low_in = num[QUO_W-1:0];
                assign den_in = den;
            end else begin : g_next
                assign rem_in = rem_reg[s-1];
                assign low_in = low_reg[s-1];
                assign den_in = den_reg[s-1];
            end

            // shift-subtract steps; quotient bits fill low from the bottom
            always_comb
            begin
                logic [DEN_W:0]   trial;
                logic [DEN_W-1:0] r;
                logic [QUO_W-1:0] l;
                r = rem_in;
                l = low_in;
                for (int j = 0; j < STEP_BITS; j++)
                begin
                    trial = {r, l[QUO_W-1]};
                    l = {l[QUO_W-2:0], 1'b0};
                    if (trial >= {1'b0, den_in})
                    begin
                        trial = trial - {1'b0, den_in};
                        l[0] = 1'b1;
                    end
                    r = trial[DEN_W-1:0];
                end
                rem_next[s] = r;
                low_next[s] = l;
            end

            always_ff @(posedge clk)
            begin
                if (load[s])
                begin
                    rem_reg[s] <= rem_next[s];
                    low_reg[s] <= low_next[s];
                    den_reg[s] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = low_reg[STAGES-1];
    assign rem = rem_reg[STAGES-1];

endmodule

[hw/rtl/hsv_range_threshold_top.sv]
// Channel   Role    Handshake      Payload
// pixel     sink    valid/ready    red, green, blue, last_pixel
// mask      source  valid/ready    in_range, last_out
// cfg       sink    valid/ready    index, data (ready tied high)
//
// One pixel per clock sustained while the mask channel accepts; the pipeline
// depth depends on DIV_STEP_BITS through the divider stages of the two
// pipelined dividers for saturation and hue.
// Every stage has its own valid bit and moves when the stage after it is
// free, so bubbles close up and a stalled mask channel loses nothing.
// Reset clears the valid bits and loads the bound registers.
module hsv_range_threshold_top #(
    parameter int DIV_STEP_BITS = hsvrt_pkg::DIV_STEP_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hsvrt_pixel_if.sink           pixel,
    hsvrt_mask_if.source          mask,
    hsvrt_cfg_if.sink             cfg
);

    localparam int DIV_STAGES = hsvrt_pkg::DIV_QUO_W / DIV_STEP_BITS;
    localparam int NUM_STAGES = DIV_STAGES + 3;
    localparam int LAST       = NUM_STAGES - 1;
    localparam int CW         = hsvrt_pkg::CHAN_W;
    localparam int HW         = hsvrt_pkg::HUE_W;
    localparam int NW         = hsvrt_pkg::DIV_NUM_W;

    // ------------------------------------------------------------------
    // Bound registers
    logic [HW-1:0] hue_low_reg, hue_high_reg;
    logic [CW-1:0] sat_low_reg, sat_high_reg, value_low_reg, value_high_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg    <= hsvrt_pkg::HUE_LOW_RST;
            hue_high_reg   <= hsvrt_pkg::HUE_HIGH_RST;
            sat_low_reg    <= hsvrt_pkg::SAT_LOW_RST;
            sat_high_reg   <= hsvrt_pkg::SAT_HIGH_RST;
            value_low_reg  <= hsvrt_pkg::VALUE_LOW_RST;
            value_high_reg <= hsvrt_pkg::VALUE_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                hsvrt_pkg::REG_HUE_LOW:    hue_low_reg    <= cfg.data[HW-1:0];
                hsvrt_pkg::REG_HUE_HIGH:   hue_high_reg   <= cfg.data[HW-1:0];
                hsvrt_pkg::REG_SAT_LOW:    sat_low_reg    <= cfg.data[CW-1:0];
                hsvrt_pkg::REG_SAT_HIGH:   sat_high_reg   <= cfg.data[CW-1:0];
                hsvrt_pkg::REG_VALUE_LOW:  value_low_reg  <= cfg.data[CW-1:0];
                hsvrt_pkg::REG_VALUE_HIGH: value_high_reg <= cfg.data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid/ready chain
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_ready, stage_load, prev_valid;

    assign stage_ready[LAST] = !valid_reg[LAST] || mask.ready;

    genvar k;
    generate
        for (k = 0; k < LAST; k++) begin : g_ready
            assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    endgenerate

    assign prev_valid  = {valid_reg[LAST-1:0], pixel.valid};
    assign stage_load  = stage_ready & prev_valid;
    assign valid_next  = (stage_ready & prev_valid) | (~stage_ready & valid_reg);
    assign pixel.ready = stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // ------------------------------------------------------------------
    // Stage 0: max, min, delta, hue sector and signed difference
    hsvrt_pkg::side_t side_reg [NUM_STAGES-1];
    hsvrt_pkg::side_t side_next;

    always_comb
    begin
        logic [CW-1:0] mx, mn, a, b;
        logic [CW:0]   diff;
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx) mx = pixel.green;
        if (pixel.blue  > mx) mx = pixel.blue;
        if (pixel.green < mn) mn = pixel.green;
        if (pixel.blue  < mn) mn = pixel.blue;

        priority if (pixel.red == mx)
        begin
            side_next.sector = hsvrt_pkg::SECTOR_RED;
            a = pixel.green;
            b = pixel.blue;
        end
        else if (pixel.green == mx)
        begin
            side_next.sector = hsvrt_pkg::SECTOR_GREEN;
            a = pixel.blue;
            b = pixel.red;
        end
        else
        begin
            side_next.sector = hsvrt_pkg::SECTOR_BLUE;
            a = pixel.red;
            b = pixel.green;
        end

        diff = {1'b0, a} - {1'b0, b};
        side_next.value    = mx;
        side_next.delta    = mx - mn;
        side_next.diff_neg = diff[CW];
        side_next.abs_diff = diff[CW] ? CW'(-diff) : diff[CW-1:0];
        side_next.last     = pixel.last_pixel;
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
            side_reg[0] <= side_next;
    end

    // side data follows the item down the pipe
    generate
        for (k = 1; k < LAST; k++) begin : g_side
            always_ff @(posedge clk)
            begin
                if (stage_load[k])
                    side_reg[k] <= side_reg[k-1];
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 1: numerators 255*delta and 60*|diff| by shift and subtract
    logic [NW-1:0] sat_num_reg, hue_num_reg;

    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            sat_num_reg <= {side_reg[0].delta, 8'd0} - {8'd0, side_reg[0].delta};
            hue_num_reg <= {2'd0, side_reg[0].abs_diff, 6'd0}
                         - {6'd0, side_reg[0].abs_diff, 2'd0};
        end
    end

    // ------------------------------------------------------------------
    // Dividers: saturation by value, hue by delta
    logic [CW-1:0] sat_quo, sat_rem, hue_quo, hue_rem;

    hsvrt_div_pipe #(
        .DEN_W     (hsvrt_pkg::DIV_DEN_W),
        .QUO_W     (hsvrt_pkg::DIV_QUO_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_sat_div (
        .clk  (clk),
        .load (stage_load[LAST-1:2]),
        .num  (sat_num_reg),
        .den  (side_reg[1].value),
        .quo  (sat_quo),
        .rem  (sat_rem)
    );

    hsvrt_div_pipe #(
        .DEN_W     (hsvrt_pkg::DIV_DEN_W),
        .QUO_W     (hsvrt_pkg::DIV_QUO_W),
        .STEP_BITS (DIV_STEP_BITS)
    ) u_hue_div (
        .clk  (clk),
        .load (stage_load[LAST-1:2]),
        .num  (hue_num_reg),
        .den  (side_reg[1].delta),
        .quo  (hue_quo),
        .rem  (hue_rem)
    );

    // ------------------------------------------------------------------
    // Last stage: floor correction, sector offset, wrap, bound checks
    hsvrt_pkg::side_t side_out;
    logic [CW-1:0] sat_val;
    logic [HW-1:0] hue_val;
    logic          in_range_next;
    logic          in_range_reg, last_reg;

    assign side_out = side_reg[LAST-1];

    always_comb
    begin
        logic [hsvrt_pkg::HUE_S_W-1:0]        q_mag;
        logic signed [hsvrt_pkg::HUE_S_W-1:0] base;
        logic signed [hsvrt_pkg::HUE_S_W-1:0] hue_s;

        // black pixel: saturation 0
        sat_val = (side_out.value == '0) ? '0 : sat_quo;

        // negative difference rounds towards minus infinity
        q_mag = {2'd0, hue_quo}
              + {{(hsvrt_pkg::HUE_S_W-1){1'b0}}, side_out.diff_neg && (hue_rem != '0)};

        unique case (side_out.sector)
            hsvrt_pkg::SECTOR_RED:   base = hsvrt_pkg::HUE_BASE_RED;
            hsvrt_pkg::SECTOR_GREEN: base = hsvrt_pkg::HUE_BASE_GREEN;
            hsvrt_pkg::SECTOR_BLUE:  base = hsvrt_pkg::HUE_BASE_BLUE;
            default:                 base = hsvrt_pkg::HUE_BASE_RED;
        endcase

        hue_s = side_out.diff_neg ? base - signed'(q_mag) : base + signed'(q_mag);
        if (hue_s < 0)
            hue_s = hue_s + hsvrt_pkg::HUE_FULL_TURN;

        // grey pixel: hue 0
        hue_val = (side_out.delta == '0) ? '0 : hue_s[HW-1:0];

        in_range_next = (side_out.value >= value_low_reg)
                     && (side_out.value <= value_high_reg)
                     && (sat_val >= sat_low_reg) && (sat_val <= sat_high_reg)
                     && (hue_val >= hue_low_reg) && (hue_val <= hue_high_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[LAST])
        begin
            in_range_reg <= in_range_next;
            last_reg     <= side_out.last;
        end
    end

    assign mask.valid    = valid_reg[LAST];
    assign mask.in_range = in_range_reg;
    assign mask.last_out = last_reg;

    // ------------------------------------------------------------------
    // Checks
    logic in_acc, out_acc;
    assign in_acc  = pixel.valid && pixel.ready;
    assign out_acc = mask.valid && mask.ready;

    // an accepted pixel always lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> valid_reg[0])
        else $error("accepted pixel not captured");

    // occupancy changes only by accepted pixels and delivered masks
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(valid_reg) == $countones($past(valid_reg))
            + ($past(in_acc) ? 1 : 0) - ($past(out_acc) ? 1 : 0)))
        else $error("item lost or duplicated in pipeline");

    // hue stays in 0..359
    a_hue: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST-1] |-> hue_val <= hsvrt_pkg::HUE_MAX)
        else $error("hue out of range");

    // hue quotient is bounded by 60 whenever delta is non-zero
    a_hue_quo: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST-1] && (side_out.delta != '0) |-> hue_quo <= hsvrt_pkg::HUE_QUO_MAX)
        else $error("hue divider quotient too large");

    // saturation remainder stays below a non-zero value
    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST-1] && (side_out.value != '0) |-> sat_rem < side_out.value)
        else $error("saturation divider remainder too large");

endmodule
